/* rtl/lmtr_pkg.sv */
// Shared types and constants for the LCD mode and timing register block.
// Holds the request and response structs, the display mode codes and register offsets.
// No dependencies.
package lmtr_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] dots;
    logic [3:0] reg_offset;
    logic [7:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       vblank_request;
    logic       stat_request;
    logic       copy_start;
    logic [7:0] copy_page;
    logic       frame_done;
  } rsp_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  localparam logic [1:0] ITEM_TICK  = 2'd0;
  localparam logic [1:0] ITEM_READ  = 2'd1;
  localparam logic [1:0] ITEM_WRITE = 2'd2;

  localparam logic [3:0] REG_CONTROL      = 4'd0;
  localparam logic [3:0] REG_STATUS       = 4'd1;
  localparam logic [3:0] REG_SCROLL_Y     = 4'd2;
  localparam logic [3:0] REG_SCROLL_X     = 4'd3;
  localparam logic [3:0] REG_LINE_COUNT   = 4'd4;
  localparam logic [3:0] REG_LINE_COMPARE = 4'd5;
  localparam logic [3:0] REG_COPY         = 4'd6;
  localparam logic [3:0] REG_BACK_PAL     = 4'd7;
  localparam logic [3:0] REG_SPRITE_PAL0  = 4'd8;
  localparam logic [3:0] REG_SPRITE_PAL1  = 4'd9;
  localparam logic [3:0] REG_WINDOW_Y     = 4'd10;
  localparam logic [3:0] REG_WINDOW_X     = 4'd11;
  localparam logic [3:0] REG_BANK         = 4'd15;

  localparam logic [12:0] LINE_DOTS    = 13'd456;
  localparam logic [12:0] HBLANK_LEN   = 13'd204;
  localparam logic [12:0] VBLANK_START = 13'd4560;
  localparam logic [12:0] OAM_LEN      = 13'd80;
  localparam logic [12:0] XFER_LEN     = 13'd172;
  localparam logic signed [10:0] COPY_DOTS = 11'sd640;
  localparam logic [7:0] STATUS_WR_MASK = 8'hF8;
  localparam logic [7:0] BANK_RESET     = 8'hFE;
  localparam logic [7:0] FIRST_VBLANK   = 8'd144;
  localparam logic [7:0] LAST_LINE      = 8'd154;

endpackage

/* rtl/lcd_mode_timing_registers_core.sv */
// Top level of the LCD mode and timing register block.
// Depends on lmtr_pkg for the request and response types and the timing constants.
//
// Each request is a tick of some dots, a register read or a register write, and yields
// exactly one response. A request passes through an input register and then a response
// register before its response is visible, and a new request is accepted every cycle as
// long as responses are taken. All register, mode and countdown updates for a request
// are made in the single cycle in which it moves from the input register to the response
// register.
module lcd_mode_timing_registers_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lmtr_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lmtr_pkg::rsp_t   rsp
);

  logic           in_valid;
  lmtr_pkg::req_t in_req;
  logic           advance;

  logic [7:0]  control_reg, status_reg, scroll_y, scroll_x, line_count, line_compare;
  logic [7:0]  back_palette, sprite_palette_zero, sprite_palette_one;
  logic [7:0]  window_y, window_x, bank_select, copy_source;
  logic [12:0] dot_clock;
  logic signed [10:0] copy_remaining;

  logic [7:0]  control_reg_next, status_reg_next, scroll_y_next, scroll_x_next;
  logic [7:0]  line_count_next, line_compare_next, back_palette_next;
  logic [7:0]  sprite_palette_zero_next, sprite_palette_one_next;
  logic [7:0]  window_y_next, window_x_next, bank_select_next, copy_source_next;
  logic [12:0] dot_clock_next;
  logic signed [10:0] copy_remaining_next;
  lmtr_pkg::rsp_t result;

  logic [12:0] dot_sum;
  logic signed [10:0] copy_left;
  logic [7:0]  line_inc;
  logic [7:0]  line_vb;
  logic        vb_step;

  assign advance   = in_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req_ready) begin
      in_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      in_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (advance) begin
      rsp <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg         <= '0;
      status_reg          <= {6'd0, lmtr_pkg::MODE_VBLANK};
      scroll_y            <= '0;
      scroll_x            <= '0;
      line_count          <= '0;
      line_compare        <= '0;
      back_palette        <= '0;
      sprite_palette_zero <= '0;
      sprite_palette_one  <= '0;
      window_y            <= '0;
      window_x            <= '0;
      bank_select         <= lmtr_pkg::BANK_RESET;
      dot_clock           <= lmtr_pkg::VBLANK_START;
      copy_remaining      <= '0;
      copy_source         <= '0;
    end else if (advance) begin
      control_reg         <= control_reg_next;
      status_reg          <= status_reg_next;
      scroll_y            <= scroll_y_next;
      scroll_x            <= scroll_x_next;
      line_count          <= line_count_next;
      line_compare        <= line_compare_next;
      back_palette        <= back_palette_next;
      sprite_palette_zero <= sprite_palette_zero_next;
      sprite_palette_one  <= sprite_palette_one_next;
      window_y            <= window_y_next;
      window_x            <= window_x_next;
      bank_select         <= bank_select_next;
      dot_clock           <= dot_clock_next;
      copy_remaining      <= copy_remaining_next;
      copy_source         <= copy_source_next;
    end
  end

  assign dot_sum   = dot_clock + {7'd0, in_req.dots};
  assign copy_left = copy_remaining - $signed({5'd0, in_req.dots});
  assign line_inc  = line_count + 8'd1;
  assign vb_step   = dot_sum >= lmtr_pkg::LINE_DOTS;
  assign line_vb   = vb_step ? line_inc : line_count;

  always_comb begin
    control_reg_next         = control_reg;
    status_reg_next          = status_reg;
    scroll_y_next            = scroll_y;
    scroll_x_next            = scroll_x;
    line_count_next          = line_count;
    line_compare_next        = line_compare;
    back_palette_next        = back_palette;
    sprite_palette_zero_next = sprite_palette_zero;
    sprite_palette_one_next  = sprite_palette_one;
    window_y_next            = window_y;
    window_x_next            = window_x;
    bank_select_next         = bank_select;
    dot_clock_next           = dot_clock;
    copy_remaining_next      = copy_remaining;
    copy_source_next         = copy_source;
    result                   = '0;

    unique case (in_req.mode)
      lmtr_pkg::ITEM_TICK: begin
        if (copy_remaining > 11'sd0) begin
          copy_remaining_next = copy_left;
          if (copy_left <= 11'sd0) begin
            result.copy_start = 1'b1;
            result.copy_page  = copy_source;
          end
        end else if (control_reg[7]) begin
          dot_clock_next = dot_sum;
          unique case (lmtr_pkg::lcd_mode_t'(status_reg[1:0]))
            lmtr_pkg::MODE_HBLANK: begin
              if (dot_sum >= lmtr_pkg::HBLANK_LEN) begin
                dot_clock_next  = dot_sum - lmtr_pkg::HBLANK_LEN;
                line_count_next = line_inc;
                if (line_inc == lmtr_pkg::FIRST_VBLANK) begin
                  status_reg_next[1:0]  = lmtr_pkg::MODE_VBLANK;
                  result.vblank_request = 1'b1;
                  result.stat_request   = status_reg[4];
                end else begin
                  status_reg_next[1:0] = lmtr_pkg::MODE_OAM;
                  result.stat_request  = status_reg[5];
                end
                status_reg_next[2] = line_inc == line_compare;
                if (line_inc == line_compare && status_reg[6]) begin
                  result.stat_request = 1'b1;
                end
              end
            end
            lmtr_pkg::MODE_VBLANK: begin
              if (vb_step) begin
                dot_clock_next     = dot_sum - lmtr_pkg::LINE_DOTS;
                line_count_next    = line_inc;
                status_reg_next[2] = line_inc == line_compare;
                if (line_inc == line_compare && status_reg[6]) begin
                  result.stat_request = 1'b1;
                end
              end
              if (line_vb == lmtr_pkg::LAST_LINE) begin
                line_count_next      = '0;
                status_reg_next[2]   = line_compare == 8'd0;
                status_reg_next[1:0] = lmtr_pkg::MODE_OAM;
                result.frame_done    = 1'b1;
                if ((line_compare == 8'd0 && status_reg[6]) || status_reg[5]) begin
                  result.stat_request = 1'b1;
                end
              end
            end
            lmtr_pkg::MODE_OAM: begin
              if (dot_sum >= lmtr_pkg::OAM_LEN) begin
                dot_clock_next       = dot_sum - lmtr_pkg::OAM_LEN;
                status_reg_next[1:0] = lmtr_pkg::MODE_XFER;
              end
            end
            lmtr_pkg::MODE_XFER: begin
              if (dot_sum >= lmtr_pkg::XFER_LEN) begin
                dot_clock_next       = dot_sum - lmtr_pkg::XFER_LEN;
                status_reg_next[1:0] = lmtr_pkg::MODE_HBLANK;
                result.stat_request  = status_reg[3];
              end
            end
          endcase
        end
      end
      lmtr_pkg::ITEM_READ: begin
        unique case (in_req.reg_offset)
          lmtr_pkg::REG_CONTROL:      result.read_value = control_reg;
          lmtr_pkg::REG_STATUS:       result.read_value = status_reg;
          lmtr_pkg::REG_SCROLL_Y:     result.read_value = scroll_y;
          lmtr_pkg::REG_SCROLL_X:     result.read_value = scroll_x;
          lmtr_pkg::REG_LINE_COUNT:   result.read_value = line_count;
          lmtr_pkg::REG_LINE_COMPARE: result.read_value = line_compare;
          lmtr_pkg::REG_BACK_PAL:     result.read_value = back_palette;
          lmtr_pkg::REG_SPRITE_PAL0:  result.read_value = sprite_palette_zero;
          lmtr_pkg::REG_SPRITE_PAL1:  result.read_value = sprite_palette_one;
          lmtr_pkg::REG_WINDOW_Y:     result.read_value = window_y;
          lmtr_pkg::REG_WINDOW_X:     result.read_value = window_x;
          lmtr_pkg::REG_BANK:         result.read_value = bank_select;
          default:                    result.read_value = 8'hFF;
        endcase
      end
      lmtr_pkg::ITEM_WRITE: begin
        unique case (in_req.reg_offset)
          lmtr_pkg::REG_CONTROL: begin
            control_reg_next = in_req.write_value;
            if (in_req.write_value[7] && !control_reg[7]) begin
              status_reg_next[2] = line_count == line_compare;
              if (line_count == line_compare && status_reg[6]) begin
                result.stat_request = 1'b1;
              end
            end
            if (!in_req.write_value[7]) begin
              line_count_next      = '0;
              dot_clock_next       = '0;
              status_reg_next[1:0] = lmtr_pkg::MODE_HBLANK;
            end
          end
          lmtr_pkg::REG_STATUS: begin
            status_reg_next = (in_req.write_value & lmtr_pkg::STATUS_WR_MASK)
                            | (status_reg & ~lmtr_pkg::STATUS_WR_MASK);
          end
          lmtr_pkg::REG_SCROLL_Y:     scroll_y_next = in_req.write_value;
          lmtr_pkg::REG_SCROLL_X:     scroll_x_next = in_req.write_value;
          lmtr_pkg::REG_LINE_COMPARE: line_compare_next = in_req.write_value;
          lmtr_pkg::REG_COPY: begin
            copy_remaining_next = lmtr_pkg::COPY_DOTS;
            copy_source_next    = in_req.write_value;
          end
          lmtr_pkg::REG_BACK_PAL:     back_palette_next = in_req.write_value;
          lmtr_pkg::REG_SPRITE_PAL0:  sprite_palette_zero_next = in_req.write_value;
          lmtr_pkg::REG_SPRITE_PAL1:  sprite_palette_one_next = in_req.write_value;
          lmtr_pkg::REG_WINDOW_Y:     window_y_next = in_req.write_value;
          lmtr_pkg::REG_WINDOW_X:     window_x_next = in_req.write_value;
          lmtr_pkg::REG_BANK: begin
            bank_select_next = {lmtr_pkg::BANK_RESET[7:1], in_req.write_value[0]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

/* rtl/lmtr_checker.sv */
// Port-level checker for the LCD mode and timing register block, and its bind.
// Depends on lmtr_pkg for the request and response types.
module lmtr_port_checks (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input lmtr_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lmtr_pkg::rsp_t rsp
);

  // A request that is not taken must hold still.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // A response that is not taken must hold still.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A copy page is only reported together with the copy start pulse.
  a_page_with_start: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.copy_start |-> rsp.copy_page == 8'd0)
    else $error("copy page without copy start");

  // A tick serving the copy countdown never advances the display timing.
  a_copy_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.copy_start |-> !rsp.vblank_request && !rsp.frame_done
                                    && !rsp.stat_request && rsp.read_value == 8'd0)
    else $error("copy start mixed with timing events");

  // Entering vertical blank and wrapping the frame cannot happen on one tick.
  a_vblank_frame: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.vblank_request && rsp.frame_done))
    else $error("vertical blank and frame wrap together");

endmodule

bind lcd_mode_timing_registers_core lmtr_port_checks u_lmtr_port_checks (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* verif/lmtr_checker.sv */
`timescale 1ns / 1ps
// Response checker for the LCD mode and timing register block.
// Watches both channels, predicts each response from its own register and timing state,
// and compares field by field. Depends on lmtr_pkg for the request and response types.
module lmtr_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  lmtr_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  lmtr_pkg::rsp_t rsp,
  output int             outstanding,
  output int             mismatches
);

  logic [7:0]         ctl, sts, scy, scx, ly, lyc, bgp, obp0, obp1, wy, wx, vbk;
  logic [12:0]        dot_acc;
  logic signed [10:0] dma_left;
  logic [7:0]         dma_page;

  lmtr_pkg::rsp_t due_q[$];
  int   error_tally = 0;
  int   rsp_seen = 0;

  assign mismatches = error_tally;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_tally++;
  endtask

  function automatic bit ly_match_irq();
    if (ly == lyc) begin
      sts[2] = 1'b1;
      return sts[6];
    end
    sts[2] = 1'b0;
    return 1'b0;
  endfunction

  task automatic lcd_predict(input lmtr_pkg::req_t r, output lmtr_pkg::rsp_t e);
    lmtr_pkg::rsp_t o;
    logic was_on;
    o = '0;
    case (r.mode)
      lmtr_pkg::ITEM_TICK: begin
        if (dma_left > 0) begin
          dma_left = dma_left - $signed({5'b0, r.dots});
          if (dma_left <= 0) begin
            o.copy_start = 1'b1;
            o.copy_page  = dma_page;
          end
        end else if (ctl[7]) begin
          dot_acc = dot_acc + {7'b0, r.dots};
          case (lmtr_pkg::lcd_mode_t'(sts[1:0]))
            lmtr_pkg::MODE_HBLANK: begin
              if (dot_acc >= lmtr_pkg::HBLANK_LEN) begin
                dot_acc = dot_acc - lmtr_pkg::HBLANK_LEN;
                ly = ly + 8'd1;
                if (ly == lmtr_pkg::FIRST_VBLANK) begin
                  sts[1:0] = lmtr_pkg::MODE_VBLANK;
                  o.vblank_request = 1'b1;
                  if (sts[4]) o.stat_request = 1'b1;
                end else begin
                  sts[1:0] = lmtr_pkg::MODE_OAM;
                  if (sts[5]) o.stat_request = 1'b1;
                end
                if (ly_match_irq()) o.stat_request = 1'b1;
              end
            end
            lmtr_pkg::MODE_VBLANK: begin
              if (dot_acc >= lmtr_pkg::LINE_DOTS) begin
                dot_acc = dot_acc - lmtr_pkg::LINE_DOTS;
                ly = ly + 8'd1;
                if (ly_match_irq()) o.stat_request = 1'b1;
              end
              if (ly == lmtr_pkg::LAST_LINE) begin
                ly = 8'd0;
                if (ly_match_irq()) o.stat_request = 1'b1;
                o.frame_done = 1'b1;
                sts[1:0] = lmtr_pkg::MODE_OAM;
                if (sts[5]) o.stat_request = 1'b1;
              end
            end
            lmtr_pkg::MODE_OAM: begin
              if (dot_acc >= lmtr_pkg::OAM_LEN) begin
                dot_acc = dot_acc - lmtr_pkg::OAM_LEN;
                sts[1:0] = lmtr_pkg::MODE_XFER;
              end
            end
            default: begin
              if (dot_acc >= lmtr_pkg::XFER_LEN) begin
                dot_acc = dot_acc - lmtr_pkg::XFER_LEN;
                sts[1:0] = lmtr_pkg::MODE_HBLANK;
                if (sts[3]) o.stat_request = 1'b1;
              end
            end
          endcase
        end
      end
      lmtr_pkg::ITEM_READ: begin
        case (r.reg_offset)
          lmtr_pkg::REG_CONTROL:      o.read_value = ctl;
          lmtr_pkg::REG_STATUS:       o.read_value = sts;
          lmtr_pkg::REG_SCROLL_Y:     o.read_value = scy;
          lmtr_pkg::REG_SCROLL_X:     o.read_value = scx;
          lmtr_pkg::REG_LINE_COUNT:   o.read_value = ly;
          lmtr_pkg::REG_LINE_COMPARE: o.read_value = lyc;
          lmtr_pkg::REG_BACK_PAL:     o.read_value = bgp;
          lmtr_pkg::REG_SPRITE_PAL0:  o.read_value = obp0;
          lmtr_pkg::REG_SPRITE_PAL1:  o.read_value = obp1;
          lmtr_pkg::REG_WINDOW_Y:     o.read_value = wy;
          lmtr_pkg::REG_WINDOW_X:     o.read_value = wx;
          lmtr_pkg::REG_BANK:         o.read_value = vbk;
          default:                    o.read_value = 8'hFF;
        endcase
      end
      lmtr_pkg::ITEM_WRITE: begin
        case (r.reg_offset)
          lmtr_pkg::REG_CONTROL: begin
            was_on = ctl[7];
            ctl = r.write_value;
            if (r.write_value[7] && !was_on) begin
              if (ly_match_irq()) o.stat_request = 1'b1;
            end
            if (!r.write_value[7]) begin
              ly = 8'd0;
              dot_acc = '0;
              sts[1:0] = lmtr_pkg::MODE_HBLANK;
            end
          end
          lmtr_pkg::REG_STATUS: begin
            sts = (r.write_value & lmtr_pkg::STATUS_WR_MASK)
                | (sts & ~lmtr_pkg::STATUS_WR_MASK);
          end
          lmtr_pkg::REG_SCROLL_Y:     scy = r.write_value;
          lmtr_pkg::REG_SCROLL_X:     scx = r.write_value;
          lmtr_pkg::REG_LINE_COMPARE: lyc = r.write_value;
          lmtr_pkg::REG_COPY: begin
            dma_left = lmtr_pkg::COPY_DOTS;
            dma_page = r.write_value;
          end
          lmtr_pkg::REG_BACK_PAL:     bgp = r.write_value;
          lmtr_pkg::REG_SPRITE_PAL0:  obp0 = r.write_value;
          lmtr_pkg::REG_SPRITE_PAL1:  obp1 = r.write_value;
          lmtr_pkg::REG_WINDOW_Y:     wy = r.write_value;
          lmtr_pkg::REG_WINDOW_X:     wx = r.write_value;
          lmtr_pkg::REG_BANK:         vbk = r.write_value[0] ? 8'hFF : lmtr_pkg::BANK_RESET;
          default: ;
        endcase
      end
      default: ;
    endcase
    e = o;
  endtask

  always @(posedge clk) begin : scoreboard
    lmtr_pkg::rsp_t want;
    if (rst) begin
      ctl = '0; scy = '0; scx = '0; ly = '0; lyc = '0; bgp = '0;
      obp0 = '0; obp1 = '0; wy = '0; wx = '0;
      sts = {6'b0, lmtr_pkg::MODE_VBLANK};
      vbk = lmtr_pkg::BANK_RESET;
      dot_acc = lmtr_pkg::VBLANK_START;
      dma_left = '0;
      dma_page = '0;
      due_q.delete();
      outstanding <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_q.size() == 0) begin
          flag_mismatch($sformatf("response %0d arrived with no request outstanding", rsp_seen));
        end else begin
          want = due_q.pop_front();
          if (rsp.read_value !== want.read_value)
            flag_mismatch($sformatf("response %0d read_value %h, expected %h",
                                    rsp_seen, rsp.read_value, want.read_value));
          if (rsp.vblank_request !== want.vblank_request)
            flag_mismatch($sformatf("response %0d vblank_request %b, expected %b",
                                    rsp_seen, rsp.vblank_request, want.vblank_request));
          if (rsp.stat_request !== want.stat_request)
            flag_mismatch($sformatf("response %0d stat_request %b, expected %b",
                                    rsp_seen, rsp.stat_request, want.stat_request));
          if (rsp.copy_start !== want.copy_start)
            flag_mismatch($sformatf("response %0d copy_start %b, expected %b",
                                    rsp_seen, rsp.copy_start, want.copy_start));
          if (rsp.copy_page !== want.copy_page)
            flag_mismatch($sformatf("response %0d copy_page %h, expected %h",
                                    rsp_seen, rsp.copy_page, want.copy_page));
          if (rsp.frame_done !== want.frame_done)
            flag_mismatch($sformatf("response %0d frame_done %b, expected %b",
                                    rsp_seen, rsp.frame_done, want.frame_done));
        end
        rsp_seen++;
      end
      if (req_valid && req_ready) begin
        lcd_predict(req, want);
        due_q.push_back(want);
      end
      outstanding <= due_q.size();
    end
  end

endmodule

/* verif/tb_lcd_mode_timing_registers_core.sv */
`timescale 1ns / 1ps
// Testbench top for lcd_mode_timing_registers_core: drives directed and random requests
// with random pacing on both channels and gives the verdict from lmtr_checker.
// Depends on lmtr_pkg, the block itself and verif/lmtr_checker.sv.
module tb_lcd_mode_timing_registers_core;

  localparam logic [1:0] ITEM_UNUSED     = 2'd3;
  localparam logic [3:0] REG_SPARE_FIRST = 4'd12;
  localparam logic [3:0] REG_SPARE_LAST  = 4'd14;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int FRAME_RUN_DOTS = 71000;
  localparam int COPY_RUN_DOTS  = 640;
  localparam int COPY_ROUNDS    = 2;
  localparam int SETTLE_CYCLES  = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  lmtr_pkg::req_t req = '0;
  logic req_ready;
  logic rsp_valid;
  lmtr_pkg::rsp_t rsp;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int stall_left = 0;
  int sent_count = 0;
  bit valid_held = 1'b0;
  bit sender_gaps = 1'b1;
  logic receiver_stalls = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lcd_mode_timing_registers_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  lmtr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : rsp_pacing
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (receiver_stalls && roll < 4) begin
      stall_left <= $urandom_range(8, 30);
      rsp_ready <= 1'b0;
    end else if (receiver_stalls && roll < 25) begin
      stall_left <= $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic push_request(input logic [1:0] kind, input logic [3:0] off,
                              input logic [5:0] dots, input logic [7:0] val);
    lmtr_pkg::req_t r;
    int roll;
    int gap;
    r.mode = kind;
    r.dots = dots;
    r.reg_offset = off;
    r.write_value = val;
    req <= r;
    req_valid <= 1'b1;
    valid_held = 1'b1;
    do @(posedge clk); while (!req_ready);
    sent_count++;
    if (sent_count % 128 == 0) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      receiver_stalls <= ($urandom_range(0, 3) != 0);
    end
    gap = 0;
    if (sender_gaps) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) gap = $urandom_range(8, 30);
      else if (roll < 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_responses();
    if (valid_held) begin
      req_valid <= 1'b0;
      valid_held = 1'b0;
    end
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A read, write or unused-mode request at a random offset. Without allow_core,
  // control and copy writes are turned into status writes so the timing keeps running.
  task automatic side_access(input bit allow_core);
    logic [3:0] off;
    logic [7:0] val;
    int roll;
    off = 4'($urandom_range(0, 15));
    val = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (off == lmtr_pkg::REG_LINE_COMPARE && roll[0]) val = 8'($urandom_range(0, 153));
    if (roll < 45) begin
      push_request(lmtr_pkg::ITEM_READ, off, 6'($urandom), 8'($urandom));
    end else if (roll < 95) begin
      if (!allow_core && (off == lmtr_pkg::REG_CONTROL || off == lmtr_pkg::REG_COPY)) begin
        off = lmtr_pkg::REG_STATUS;
      end
      push_request(lmtr_pkg::ITEM_WRITE, off, 6'($urandom), val);
    end else begin
      push_request(ITEM_UNUSED, off, 6'($urandom), val);
    end
  endtask

  initial begin : stimulus
    int frame_dots;
    int copy_dots;
    int d;
    int roll;
    int round;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_STATUS, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_BANK, 6'h3F, 8'hFF);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_COPY, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_READ, REG_SPARE_LAST, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_LINE_COUNT, 6'd0, 8'hFF);
    push_request(lmtr_pkg::ITEM_WRITE, REG_SPARE_FIRST, 6'd0, 8'hAA);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_STATUS, 6'd0, 8'hFF);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_STATUS, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_BANK, 6'd0, 8'h01);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_BANK, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_SCROLL_Y, 6'd0, 8'hFF);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_WINDOW_X, 6'd0, 8'h80);
    push_request(ITEM_UNUSED, lmtr_pkg::REG_BANK, 6'h3F, 8'hFF);
    push_request(lmtr_pkg::ITEM_TICK, 4'd0, 6'h3F, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'd0, 8'h80);
    push_request(lmtr_pkg::ITEM_TICK, 4'd0, 6'h3F, 8'h00);
    push_request(lmtr_pkg::ITEM_TICK, 4'd0, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_LINE_COUNT, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'd0, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'd0, 8'h91);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_COPY, 6'd0, 8'h5A);
    push_request(lmtr_pkg::ITEM_TICK, 4'd0, 6'h3F, 8'h00);
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_COPY, 6'd0, 8'hC3);
    push_request(lmtr_pkg::ITEM_READ, lmtr_pkg::REG_STATUS, 6'd0, 8'h00);
    wait_for_responses();

    // A copy countdown is run out first, then one long run with the display on and no copy, so a whole frame goes by.
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_COPY, 6'($urandom), 8'($urandom));
    copy_dots = 0;
    while (copy_dots < COPY_RUN_DOTS) begin
      d = $urandom_range(0, 63);
      push_request(lmtr_pkg::ITEM_TICK, 4'($urandom), 6'(d), 8'($urandom));
      copy_dots += d;
    end
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'($urandom),
                 8'($urandom_range(0, 127)));
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_STATUS, 6'($urandom), 8'($urandom));
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_LINE_COMPARE, 6'($urandom),
                 8'($urandom_range(0, 153)));
    push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'($urandom),
                 8'h80 | 8'($urandom_range(0, 127)));
    frame_dots = 0;
    while (frame_dots < FRAME_RUN_DOTS) begin
      if ($urandom_range(0, 99) < 5) begin
        side_access(1'b0);
      end else begin
        d = ($urandom_range(0, 99) < 85) ? $urandom_range(44, 63) : $urandom_range(0, 63);
        push_request(lmtr_pkg::ITEM_TICK, 4'($urandom), 6'(d), 8'($urandom));
        frame_dots += d;
      end
    end
    wait_for_responses();

    // Copy countdowns with the display in random states, followed by free noise.
    for (round = 0; round < COPY_ROUNDS; round++) begin
      if ($urandom_range(0, 1)) begin
        push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_CONTROL, 6'($urandom), 8'($urandom));
      end
      push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_COPY, 6'($urandom), 8'($urandom));
      copy_dots = 0;
      while (copy_dots < COPY_RUN_DOTS) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          side_access(1'b0);
        end else if (roll < 22) begin
          push_request(lmtr_pkg::ITEM_WRITE, lmtr_pkg::REG_COPY, 6'($urandom), 8'($urandom));
          copy_dots = 0;
        end else begin
          d = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 32) : $urandom_range(0, 63);
          push_request(lmtr_pkg::ITEM_TICK, 4'($urandom), 6'(d), 8'($urandom));
          copy_dots += d;
        end
      end
      repeat (10) begin
        if ($urandom_range(0, 1)) begin
          push_request(lmtr_pkg::ITEM_TICK, 4'($urandom), 6'($urandom), 8'($urandom));
        end else begin
          side_access(1'b1);
        end
      end
    end

    wait_for_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
